// ----- hw/rtl/tbads_pkg.sv -----
// shared constants, widths and the dead-zone function for the tilt block averager
`default_nettype none

package tbads_pkg;

   // block size and derived widths (block size is a power of two)
   localparam int SAMPLES_PER_BLOCK = 16;
   localparam int SAMPLE_W          = 16;
   localparam int COUNT_W           = $clog2(SAMPLES_PER_BLOCK);
   localparam int SUM_W             = SAMPLE_W + COUNT_W;
   // mean in half degrees: sum / (128 * samples per block)
   localparam int ROUND_SHIFT       = 7 + COUNT_W;

   // result field widths
   localparam int ANGLE_W  = 10;
   localparam int FACTOR_W = 11;
   localparam int SPEED_W  = 20;
   localparam int CANGLE_W = 6;
   localparam int CSPEED_W = 17;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = FACTOR_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MOTION_ENABLE = 1'b0,
      CSR_SPEED_FACTOR  = 1'b1
   } csr_index_type;

   localparam logic                MOTION_ENABLE_RESET = 1'b1;
   localparam logic [FACTOR_W-1:0] SPEED_FACTOR_RESET  = FACTOR_W'(694);

   // dead-zone breakpoints, in half degrees
   localparam logic signed [ANGLE_W-1:0]  DZ_LOW_EDGE    = -ANGLE_W'(7);
   localparam logic signed [ANGLE_W-1:0]  DZ_MID_EDGE    = -ANGLE_W'(3);
   localparam logic signed [ANGLE_W-1:0]  DZ_ZERO_LOW    = -ANGLE_W'(2);
   localparam logic signed [ANGLE_W-1:0]  DZ_ZERO_HIGH   = ANGLE_W'(4);
   localparam logic signed [ANGLE_W-1:0]  DZ_LINEAR_HIGH = ANGLE_W'(24);
   localparam logic signed [ANGLE_W-1:0]  DZ_OFFSET      = ANGLE_W'(4);
   localparam logic signed [CANGLE_W-1:0] DZ_FAR_NEG     = -CANGLE_W'(10);
   localparam logic signed [CANGLE_W-1:0] DZ_NEAR_NEG    = -CANGLE_W'(4);
   localparam logic signed [CANGLE_W-1:0] DZ_FAR_POS     = CANGLE_W'(20);

   // dead-zone correction of a half-degree angle
   function automatic logic signed [CANGLE_W-1:0] dead_zone(
      input logic signed [ANGLE_W-1:0] angle
   );
      logic signed [ANGLE_W-1:0] shifted;
      shifted = angle - DZ_OFFSET;
      if (angle >= DZ_ZERO_LOW && angle <= DZ_ZERO_HIGH) begin
         return '0;
      end else if (angle <= DZ_LOW_EDGE) begin
         return DZ_FAR_NEG;
      end else if (angle <= DZ_MID_EDGE) begin
         return DZ_NEAR_NEG;
      end else if (angle <= DZ_LINEAR_HIGH) begin
         return shifted[CANGLE_W-1:0];
      end else begin
         return DZ_FAR_POS;
      end
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tbads_accum.sv -----
// block accumulator: sums samples and hands out one block sum per full block
`default_nettype none

module tbads_accum
   import tbads_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  signed [SAMPLE_W-1:0] req_tilt_sample,
   output logic                       blk_valid,
   input  wire                        blk_take,
   output logic signed [SUM_W-1:0]    blk_sum
);

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    blk_valid_ff, blk_valid_in;
   logic signed [SUM_W-1:0] blk_sum_ff, blk_sum_in;
   logic                    last_sample;
   logic                    blk_free;
   logic                    accept;
   logic signed [SUM_W-1:0] sum_next;

   // only the closing sample of a block needs room in the block register
   assign last_sample = (count_ff == COUNT_W'(SAMPLES_PER_BLOCK - 1));
   assign blk_free    = !blk_valid_ff || blk_take;
   assign req_stall   = last_sample && !blk_free;
   assign accept      = req_valid && !req_stall;
   assign sum_next    = sum_ff + SUM_W'(req_tilt_sample);

   // accumulate, and close the block on its last sample
   always_comb begin
      sum_in       = sum_ff;
      count_in     = count_ff;
      blk_valid_in = blk_valid_ff && !blk_take;
      blk_sum_in   = blk_sum_ff;
      if (accept) begin
         if (last_sample) begin
            sum_in       = '0;
            count_in     = '0;
            blk_valid_in = 1'b1;
            blk_sum_in   = sum_next;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   // control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         blk_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         blk_valid_ff <= blk_valid_in;
      end
   end

   // block sum payload
   always_ff @(posedge clock) begin
      blk_sum_ff <= blk_sum_in;
   end

   assign blk_valid = blk_valid_ff;
   assign blk_sum   = blk_sum_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tilt_block_average_deadzone_speed.sv -----
// tilt block averager top level: mean rounding, dead zone and speed scaling
// the closing sample of a block passes through the block register, the angle stage and the result register
// throughput: one sample word per cycle while req_stall is low; one result word per 16 samples
// a sample that does not close a block is taken even while the result side stalls
// reset (synchronous): accumulator and count cleared, pipeline emptied,
// motion enable set and speed factor set to 694 tenths per half degree
`default_nettype none

module tilt_block_average_deadzone_speed
   import tbads_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  signed [SAMPLE_W-1:0]  req_tilt_sample,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic signed [ANGLE_W-1:0]   rsp_angle_half_deg,
   output logic signed [SPEED_W-1:0]   rsp_speed_tenths,
   output logic signed [CANGLE_W-1:0]  rsp_corrected_angle_half_deg,
   output logic signed [CSPEED_W-1:0]  rsp_corrected_speed_tenths,
   input  wire                         csr_write_enable,
   input  wire  [CSR_INDEX_W-1:0]      csr_index,
   input  wire  [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int PROD_W  = ANGLE_W + FACTOR_W + 1;
   localparam int CPROD_W = CANGLE_W + FACTOR_W + 1;

   logic                  motion_enable_ff, motion_enable_in;
   logic [FACTOR_W-1:0]   factor_ff, factor_in;

   logic                  blk_valid;
   logic                  blk_take;
   logic signed [SUM_W-1:0] blk_sum;

   logic                          ang_valid_ff, ang_valid_in;
   logic signed [ANGLE_W-1:0]     ang_ff, ang_in;
   logic signed [CANGLE_W-1:0]    cang_ff, cang_in;
   logic signed [SUM_W:0]         rounded;

   logic                          out_valid_ff, out_valid_in;
   logic signed [ANGLE_W-1:0]     out_angle_ff, out_angle_in;
   logic signed [SPEED_W-1:0]     out_speed_ff, out_speed_in;
   logic signed [CANGLE_W-1:0]    out_cangle_ff, out_cangle_in;
   logic signed [CSPEED_W-1:0]    out_cspeed_ff, out_cspeed_in;
   logic signed [PROD_W-1:0]      speed_prod;
   logic signed [CPROD_W-1:0]     cspeed_prod;
   logic signed [FACTOR_W:0]      factor_signed;

   logic out_free;
   logic ang_free;
   logic ang_move;

   // configuration registers
   always_comb begin
      motion_enable_in = motion_enable_ff;
      factor_in        = factor_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MOTION_ENABLE: motion_enable_in = csr_wdata[0];
            CSR_SPEED_FACTOR:  factor_in        = csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_enable_ff <= MOTION_ENABLE_RESET;
         factor_ff        <= SPEED_FACTOR_RESET;
      end else begin
         motion_enable_ff <= motion_enable_in;
         factor_ff        <= factor_in;
      end
   end

   // sample accumulation
   tbads_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tilt_sample (req_tilt_sample),
      .blk_valid       (blk_valid),
      .blk_take        (blk_take),
      .blk_sum         (blk_sum)
   );

   // pipeline flow: each stage moves when the one after it has room
   assign out_free = !out_valid_ff || !rsp_stall;
   assign ang_move = ang_valid_ff && out_free;
   assign ang_free = !ang_valid_ff || ang_move;
   assign blk_take = blk_valid && ang_free;

   // round the block mean up to half degrees (floor of sum plus divisor minus one)
   assign rounded = ((SUM_W+1)'(blk_sum) + (SUM_W+1)'((1 << ROUND_SHIFT) - 1)) >>> ROUND_SHIFT;

   always_comb begin
      ang_valid_in = blk_take || (ang_valid_ff && !ang_move);
      ang_in       = ang_ff;
      cang_in      = cang_ff;
      if (blk_take) begin
         ang_in  = rounded[ANGLE_W-1:0];
         cang_in = dead_zone(rounded[ANGLE_W-1:0]);
      end
   end

   // speed scaling into the result register
   assign factor_signed = $signed({1'b0, factor_ff});
   assign speed_prod    = PROD_W'(ang_ff) * PROD_W'(factor_signed);
   assign cspeed_prod   = CPROD_W'(cang_ff) * CPROD_W'(factor_signed);

   always_comb begin
      out_valid_in  = ang_move || (out_valid_ff && rsp_stall);
      out_angle_in  = out_angle_ff;
      out_speed_in  = out_speed_ff;
      out_cangle_in = out_cangle_ff;
      out_cspeed_in = out_cspeed_ff;
      if (ang_move) begin
         out_angle_in  = ang_ff;
         out_speed_in  = speed_prod[SPEED_W-1:0];
         out_cangle_in = cang_ff;
         out_cspeed_in = motion_enable_ff ? cspeed_prod[CSPEED_W-1:0] : '0;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ang_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ang_valid_ff <= ang_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      ang_ff        <= ang_in;
      cang_ff       <= cang_in;
      out_angle_ff  <= out_angle_in;
      out_speed_ff  <= out_speed_in;
      out_cangle_ff <= out_cangle_in;
      out_cspeed_ff <= out_cspeed_in;
   end

   assign rsp_valid                    = out_valid_ff;
   assign rsp_angle_half_deg           = out_angle_ff;
   assign rsp_speed_tenths             = out_speed_ff;
   assign rsp_corrected_angle_half_deg = out_cangle_ff;
   assign rsp_corrected_speed_tenths   = out_cspeed_ff;

endmodule

`default_nettype wire
